// ----- rtl/core/pphist_pkg.sv -----
// pphist_pkg: beat types, action and status codes and sizing constants
// for the ping-pong packet history; no dependencies
package pphist_pkg;

    localparam int BANK_DEPTH    = 16;
    localparam int PAYLOAD_WIDTH = 64;

    localparam int HELD_MAX = 2 * BANK_DEPTH;
    localparam int FILL_W   = $clog2(BANK_DEPTH + 1);
    localparam int HELD_W   = $clog2(HELD_MAX + 1);
    localparam int ADDR_W   = $clog2(HELD_MAX);
    localparam int WORD_W   = PAYLOAD_WIDTH + 32;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_LATEST = 2'd1;
    localparam logic [1:0] ACT_SINCE  = 2'd2;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_NODATA  = 2'd1;
    localparam logic [1:0] ST_SUCCESS = 2'd2;
    localparam logic [1:0] ST_PARTIAL = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] payload;
        logic [7:0]  request_total;
        logic [31:0] start_sequence;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        has_packet;
        logic [31:0] sequence_number;
        logic [63:0] packet_data;
        logic        last;
    } out_beat_t;

endpackage

// ----- rtl/core/ping_pong_packet_history.sv -----
// ping_pong_packet_history: packet history in two ping-pong banks of one ram
// depends on pphist_pkg and pphist_ram
//
// A push or a query that finds nothing gives one result beat and, with the
// result side ready, the block takes one input beat per cycle. A query that
// returns N packets is decoded as it is taken, then streams one packet per
// cycle from the shared ram read port while the result side takes them; each
// read goes through the ram output register into the result register, and
// the next input beat is taken once the last read has left the ram output
// register. The ram read port sets the streaming rate. There is no clearing
// pass after reset: the fill counts keep every read on a written entry.
module ping_pong_packet_history (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pphist_pkg::in_beat_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pphist_pkg::out_beat_t m_data
);
    import pphist_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    logic              state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [FILL_W-1:0] wfill_reg, wfill_next;
    logic [FILL_W-1:0] rfill_reg, rfill_next;
    logic [31:0]       next_seq_reg, next_seq_next;
    logic [31:0]       oldest_reg, oldest_next;
    logic [HELD_W-1:0] pos_reg, pos_next;
    logic [1:0]        qstat_reg, qstat_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;

    logic [HELD_W-1:0] held;
    logic              in_fire;
    logic              out_free;
    logic              issue;
    logic              q_nodata;
    logic [HELD_W-1:0] q_first;
    logic [1:0]        q_status;
    logic [31:0]       offset;
    logic [FILL_W-1:0] wfill_inc;
    logic [ADDR_W-1:0] bank_base;
    logic [ADDR_W-1:0] rbank_base;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    logic              is_push;

    assign held     = HELD_W'(rfill_reg) + HELD_W'(wfill_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && !pend_reg && out_free;
    assign in_fire  = s_valid && s_ready;
    assign is_push  = (s_data.action == ACT_PUSH);
    assign issue    = (state_reg == S_STREAM) && (!pend_reg || out_free);
    assign offset   = s_data.start_sequence - oldest_reg;
    assign wfill_inc = wfill_reg + FILL_W'(1);

    assign bank_base  = bank_reg ? ADDR_W'(BANK_DEPTH) : '0;
    assign rbank_base = bank_reg ? '0 : ADDR_W'(BANK_DEPTH);
    assign waddr      = bank_base + ADDR_W'(wfill_reg);

    always_comb begin
        if (pos_reg < HELD_W'(rfill_reg)) begin
            raddr = rbank_base + ADDR_W'(pos_reg);
        end else begin
            raddr = bank_base + ADDR_W'(pos_reg - HELD_W'(rfill_reg));
        end
    end

    // query decode
    always_comb begin
        q_nodata = 1'b1;
        q_first  = '0;
        q_status = ST_NODATA;
        unique case (s_data.action)
            ACT_LATEST: begin
                if (s_data.request_total != 8'd0 && held != '0) begin
                    q_nodata = 1'b0;
                    if (s_data.request_total <= 8'(held)) begin
                        q_first  = held - HELD_W'(s_data.request_total);
                        q_status = ST_SUCCESS;
                    end else begin
                        q_status = ST_PARTIAL;
                    end
                end
            end
            ACT_SINCE: begin
                if (held != '0) begin
                    if (offset < 32'(held)) begin
                        q_nodata = 1'b0;
                        q_first  = HELD_W'(offset);
                        q_status = ST_SUCCESS;
                    end else if (s_data.start_sequence < oldest_reg) begin
                        q_nodata = 1'b0;
                        q_status = ST_PARTIAL;
                    end
                end
            end
            default: begin
                q_nodata = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        wfill_next     = wfill_reg;
        rfill_next     = rfill_reg;
        next_seq_next  = next_seq_reg;
        oldest_next    = oldest_reg;
        pos_next       = pos_reg;
        qstat_next     = qstat_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.last = 1'b1;
                    if (is_push) begin
                        m_data_next.status          = ST_STORED;
                        m_data_next.sequence_number = next_seq_reg;
                        next_seq_next = next_seq_reg + 32'd1;
                        if (wfill_inc == FILL_W'(BANK_DEPTH)) begin
                            bank_next   = !bank_reg;
                            rfill_next  = FILL_W'(BANK_DEPTH);
                            wfill_next  = '0;
                            oldest_next = next_seq_reg + 32'd1 - 32'(BANK_DEPTH);
                        end else begin
                            wfill_next = wfill_inc;
                        end
                    end else if (q_nodata) begin
                        m_data_next.status = ST_NODATA;
                    end else begin
                        m_valid_next = m_valid_reg && !m_ready;
                        m_data_next  = m_data_reg;
                        pos_next     = q_first;
                        qstat_next   = q_status;
                        state_next   = S_STREAM;
                    end
                end
            end
            S_STREAM: begin
                if (issue) begin
                    pend_last_next = (pos_reg == held - HELD_W'(1));
                    pos_next       = pos_reg + HELD_W'(1);
                    if (pos_reg == held - HELD_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // ram output register into the result register
        if (pend_reg && out_free) begin
            m_valid_next                = 1'b1;
            m_data_next.status          = qstat_reg;
            m_data_next.has_packet      = 1'b1;
            m_data_next.sequence_number = rdata[WORD_W-1:PAYLOAD_WIDTH];
            m_data_next.packet_data     = 64'(rdata[PAYLOAD_WIDTH-1:0]);
            m_data_next.last            = pend_last_reg;
            pend_next                   = 1'b0;
        end
        if (issue) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            wfill_reg     <= '0;
            rfill_reg     <= '0;
            next_seq_reg  <= '0;
            oldest_reg    <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            wfill_reg     <= wfill_next;
            rfill_reg     <= rfill_next;
            next_seq_reg  <= next_seq_next;
            oldest_reg    <= oldest_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        qstat_reg     <= qstat_next;
        pend_last_reg <= pend_last_next;
        m_data_reg    <= m_data_next;
    end

    pphist_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HELD_MAX)
    ) u_store (
        .aclk  (aclk),
        .we    (in_fire && is_push),
        .waddr (waddr),
        .wdata ({next_seq_reg, s_data.payload[PAYLOAD_WIDTH-1:0]}),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_wfill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wfill_reg < FILL_W'(BANK_DEPTH))
        else $error("write bank fill out of range");

    a_rfill_value: assert property (@(posedge aclk) disable iff (!aresetn)
        rfill_reg == '0 || rfill_reg == FILL_W'(BANK_DEPTH))
        else $error("read bank fill neither empty nor full");

    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_reg && state_reg == S_IDLE)
        else $error("input taken while a read is outstanding");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> pos_reg < held)
        else $error("ram read beyond held packets");
`endif

endmodule

// ----- rtl/core/pphist_ram.sv -----
// pphist_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module pphist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
